// ===== hdl/grce_pkg.sv =====
package grce_pkg;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;

   localparam logic [CSR_INDEX_W-1:0] CSR_FONT_HEIGHT = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FONT_WIDTH  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_LINE_PITCH  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_BASE  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_FG_COLOR    = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_BG_COLOR    = 3'd5;

   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_DRAW = 1'b1;

   // most lines one character can produce, whatever the store holds
   localparam int RESULT_LIMIT = 32;

   typedef struct packed {
      logic       cmd;
      logic [7:0] char_code;
      logic [7:0] char_row;
      logic [7:0] char_column;
      logic [4:0] glyph_line;
      logic [7:0] glyph_bits;
      logic       reverse_video;
      logic       underline;
      logic       final_char;
   } req_type;

   typedef struct packed {
      logic [31:0] pixel_address;
      logic [31:0] pixels_left;
      logic [31:0] pixels_right;
      logic        last_line;
      logic        string_done;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL1,
      ST_MUL2,
      ST_BASE,
      ST_LINES,
      ST_DRAIN
   } state_type;

   // four glyph bits, MSB leftmost, to four pixel bytes, leftmost in the top byte
   function automatic logic [31:0] expand4(input logic [3:0] bits4,
                                           input logic [7:0] fg,
                                           input logic [7:0] bg);
      logic [31:0] word;
      word = '0;
      for (int k = 0; k < 4; k++) begin
         word[24 - 8 * k +: 8] = bits4[3 - k] ? fg : bg;
      end
      return word;
   endfunction

endpackage

// ===== hdl/grce_font_ram.sv =====
module grce_font_ram #(
   parameter int DEPTH = 8192,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [7:0]        wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [7:0]        rd_data
);

   logic [7:0] mem [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // hold read data until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/glyph_row_color_expander.sv =====
// Flow: after acceptance a draw passes three setup states (ST_MUL1 and ST_MUL2 multiply,
// ST_BASE adds), then issues its lines in ST_LINES through the registered store read and
// the output register, one result per cycle while rsp_ready stays high, and ends in
// ST_DRAIN; a load transaction is taken in ST_IDLE, and loads are accepted back to back.
// Reset: synchronous; control and configuration registers take their defaults,
// the font store keeps its contents and is undefined until loaded.
module glyph_row_color_expander #(
   parameter int MAX_GLYPH_LINES = 32,
   parameter int GLYPH_COUNT     = 256
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  grce_pkg::req_type                req_payload,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output grce_pkg::rsp_type                rsp_payload,
   input  logic                             csr_we,
   input  logic [grce_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [grce_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   import grce_pkg::*;

   localparam int STORE_DEPTH  = GLYPH_COUNT * MAX_GLYPH_LINES;
   localparam int ADDR_W       = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
   localparam int HEIGHT_LIMIT = (MAX_GLYPH_LINES < RESULT_LIMIT) ? MAX_GLYPH_LINES
                                                                  : RESULT_LIMIT;

   // character code wrap table: code modulo the glyph count, built at elaboration
   function automatic logic [2047:0] build_wrap_table();
      logic [2047:0] tbl;
      tbl = '0;
      for (int i = 0; i < 256; i++) begin
         tbl[i * 8 +: 8] = 8'(i % GLYPH_COUNT);
      end
      return tbl;
   endfunction

   localparam logic [2047:0] CODE_WRAP_TABLE = build_wrap_table();

   // configuration registers
   logic [5:0]  font_height_ff;
   logic [5:0]  font_width_ff;
   logic [15:0] line_pitch_ff;
   logic [31:0] frame_base_ff;
   logic [7:0]  fg_color_ff;
   logic [7:0]  bg_color_ff;

   // sequencer state
   state_type   state_ff, state_in;

   // draw context, captured at acceptance and in the setup states
   req_type           item_ff;
   logic [5:0]        height_ff;
   logic [ADDR_W-1:0] glyph_base_ff;
   logic [13:0]       row_lines_ff;
   logic [13:0]       col_offset_ff;
   logic [29:0]       row_offset_ff;
   logic [31:0]       addr_ff;
   logic [4:0]        line_ff;

   // line in flight through the store read
   logic        pend_ff, pend_in;
   logic [31:0] pend_addr_ff;
   logic        pend_last_ff;

   // output register
   logic        out_valid_ff, out_valid_in;
   rsp_type     out_ff;

   logic              accept;
   logic              issue;
   logic              load_out;
   logic              last_issue;
   logic [7:0]        code_wrap;
   logic [5:0]        height_clamped;
   logic              load_wr_en;
   logic [ADDR_W-1:0] load_addr;
   logic [ADDR_W-1:0] read_addr;
   logic [7:0]        glyph_data;
   logic [7:0]        shaded;

   assign accept    = req_valid && req_ready;
   assign code_wrap = CODE_WRAP_TABLE[{req_payload.char_code, 3'b000} +: 8];

   // zero height acts as one; clamp to the store depth and the result limit
   always_comb begin
      if (font_height_ff == 6'd0) begin
         height_clamped = 6'd1;
      end else if (32'(font_height_ff) > HEIGHT_LIMIT) begin
         height_clamped = 6'(HEIGHT_LIMIT);
      end else begin
         height_clamped = font_height_ff;
      end
   end

   // load transactions write the store directly; lines beyond the store drop
   assign load_wr_en = accept && (req_payload.cmd == CMD_LOAD) &&
                       (32'(req_payload.glyph_line) < MAX_GLYPH_LINES);
   assign load_addr  = ADDR_W'(32'(code_wrap) * MAX_GLYPH_LINES +
                               32'(req_payload.glyph_line));
   assign read_addr  = ADDR_W'(32'(glyph_base_ff) + 32'(line_ff));

   assign last_issue = (line_ff == 5'(height_ff - 6'd1));

   grce_font_ram #(
      .DEPTH (STORE_DEPTH)
   ) u_font_ram (
      .clock   (clock),
      .wr_en   (load_wr_en),
      .wr_addr (load_addr),
      .wr_data (req_payload.glyph_bits),
      .rd_en   (issue),
      .rd_addr (read_addr),
      .rd_data (glyph_data)
   );

   // configuration writes; unknown indexes drop
   always_ff @(posedge clock) begin
      if (reset) begin
         font_height_ff <= 6'd16;
         font_width_ff  <= 6'd8;
         line_pitch_ff  <= 16'd1024;
         frame_base_ff  <= 32'd0;
         fg_color_ff    <= 8'd15;
         bg_color_ff    <= 8'd0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_FONT_HEIGHT: font_height_ff <= csr_wdata[5:0];
            CSR_FONT_WIDTH:  font_width_ff  <= csr_wdata[5:0];
            CSR_LINE_PITCH:  line_pitch_ff  <= csr_wdata[15:0];
            CSR_FRAME_BASE:  frame_base_ff  <= csr_wdata;
            CSR_FG_COLOR:    fg_color_ff    <= csr_wdata[7:0];
            CSR_BG_COLOR:    bg_color_ff    <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && (req_payload.cmd == CMD_DRAW)) begin
               state_in = ST_MUL1;
            end
         end
         ST_MUL1:  state_in = ST_MUL2;
         ST_MUL2:  state_in = ST_BASE;
         ST_BASE:  state_in = ST_LINES;
         ST_LINES: begin
            if (issue && last_issue) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!pend_ff || load_out) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs: issue a read only when no line is in flight or the line in flight leaves this cycle
   always_comb begin
      req_ready = (state_ff == ST_IDLE);
      load_out  = pend_ff && (!out_valid_ff || rsp_ready);
      issue     = (state_ff == ST_LINES) && (!pend_ff || load_out);
   end

   always_comb begin
      pend_in = pend_ff;
      if (issue) begin
         pend_in = 1'b1;
      end else if (load_out) begin
         pend_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (load_out) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pend_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // address arithmetic: two multiplies in ST_MUL1, one in ST_MUL2, the sum in ST_BASE, then step by the pitch per line
   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff       <= req_payload;
         height_ff     <= height_clamped;
         glyph_base_ff <= ADDR_W'(32'(code_wrap) * MAX_GLYPH_LINES);
      end
      if (state_ff == ST_MUL1) begin
         row_lines_ff  <= 14'(item_ff.char_row) * 14'(height_ff);
         col_offset_ff <= 14'(item_ff.char_column) * 14'(font_width_ff);
      end
      if (state_ff == ST_MUL2) begin
         row_offset_ff <= 30'(row_lines_ff) * 30'(line_pitch_ff);
      end
      if (state_ff == ST_BASE) begin
         addr_ff <= frame_base_ff + 32'(row_offset_ff) + 32'(col_offset_ff);
         line_ff <= 5'd0;
      end
      if (issue) begin
         pend_addr_ff <= addr_ff;
         pend_last_ff <= last_issue;
         addr_ff      <= addr_ff + 32'(line_pitch_ff);
         line_ff      <= line_ff + 5'd1;
      end
   end

   // underline forces the last line set, reverse video then inverts
   always_comb begin
      shaded = glyph_data;
      if (item_ff.underline && pend_last_ff) begin
         shaded = 8'hff;
      end
      if (item_ff.reverse_video) begin
         shaded = ~shaded;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         out_ff.pixel_address <= pend_addr_ff;
         out_ff.pixels_left   <= expand4(shaded[7:4], fg_color_ff, bg_color_ff);
         out_ff.pixels_right  <= expand4(shaded[3:0], fg_color_ff, bg_color_ff);
         out_ff.last_line     <= pend_last_ff;
         out_ff.string_done   <= pend_last_ff && item_ff.final_char;
      end
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_ff;

endmodule
